>>> sv/oneshot_motor_pwm_with_timebase_unit_macros.svh
`ifndef ONESHOT_MOTOR_PWM_WITH_TIMEBASE_UNIT_MACROS_SVH
`define ONESHOT_MOTOR_PWM_WITH_TIMEBASE_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define OMPWM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Same-cycle implication built on the clocked form
`define OMPWM_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    `OMPWM_ASSERT(label, clk, rstn, (ante) |-> (cons), msg)

`endif

>>> sv/ompwm_pkg.sv
package ompwm_pkg;

    // Default sizes
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int COUNT_WIDTH_DEF  = 12;

    // Register field widths
    localparam int PERIOD_W = 12;
    localparam int STEP_W   = 12;
    localparam int BASE_W   = 11;
    localparam int TMAX_W   = 11;
    localparam int SHIFT_W  = 3;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;

    // Item field widths
    localparam int CHAN_W   = 2;
    localparam int MOTOR_W  = 16;
    localparam int TIME_W   = 32;
    localparam int S_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_SHIFT   = 3'd4;

    // Reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD_TICKS = 12'd2500;
    localparam logic [STEP_W-1:0]   RST_TIME_STEP    = 12'd312;
    localparam logic [BASE_W-1:0]   RST_PULSE_BASE   = 11'd1000;
    localparam logic [TMAX_W-1:0]   RST_THROTTLE_MAX = 11'd1000;
    localparam logic [SHIFT_W-1:0]  RST_TICK_SHIFT   = 3'd3;

    // Per-item control from the timebase to every channel
    typedef struct packed {
        logic tick;    // a tick item was accepted
        logic wrap;    // this tick wraps the period
        logic reload;  // wrap with the radio idle: compares reload
    } ompwm_ctrl_t;

endpackage

>>> sv/ompwm_timebase.sv
module ompwm_timebase #(
    parameter int COUNT_WIDTH = ompwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              tick,
    input  logic                              radio_busy,
    input  logic [ompwm_pkg::PERIOD_W-1:0]    period_ticks,
    input  logic [ompwm_pkg::STEP_W-1:0]      time_step_us,
    input  logic [ompwm_pkg::SHIFT_W-1:0]     tick_shift,
    output ompwm_pkg::ompwm_ctrl_t            ctrl,
    output logic [COUNT_WIDTH-1:0]            count_next,
    output logic [ompwm_pkg::TIME_W-1:0]      time_next
);
    import ompwm_pkg::*;

    localparam int PW = (COUNT_WIDTH + 1 > PERIOD_W) ? COUNT_WIDTH + 1 : PERIOD_W;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [TIME_W-1:0]      accum_reg;
    logic [TIME_W-1:0]      accum_next;
    logic [TIME_W-1:0]      accum_step;
    logic [COUNT_WIDTH:0]   count_inc;
    logic                   wrap;

    // Wrap when the incremented count reaches the period
    assign count_inc  = {1'b0, count_reg} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    assign wrap       = tick && (PW'(count_inc) >= PW'(period_ticks));
    assign count_next = !tick ? count_reg :
                        (wrap ? '0 : count_inc[COUNT_WIDTH-1:0]);

    // Time accumulator grows by one step at each wrap
    assign accum_step = accum_reg + TIME_W'(time_step_us);
    assign accum_next = wrap ? accum_step : accum_reg;

    // After a wrap the count is zero, so the readout is the new accumulator
    assign time_next = wrap ? accum_step
                            : accum_reg + TIME_W'(count_next >> tick_shift);

    assign ctrl.tick   = tick;
    assign ctrl.wrap   = wrap;
    assign ctrl.reload = wrap && !radio_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            accum_reg <= '0;
        end else begin
            count_reg <= count_next;
            accum_reg <= accum_next;
        end
    end

endmodule

>>> sv/ompwm_channel.sv
module ompwm_channel #(
    parameter int COUNT_WIDTH = ompwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ompwm_pkg::ompwm_ctrl_t          ctrl,
    input  logic [COUNT_WIDTH-1:0]          count_next,
    input  logic                            wr_en,
    input  logic [ompwm_pkg::MOTOR_W-1:0]   wr_value,
    input  logic [ompwm_pkg::BASE_W-1:0]    pulse_base_ticks,
    input  logic [ompwm_pkg::TMAX_W-1:0]    throttle_max,
    output logic                            pin_next
);
    import ompwm_pkg::*;

    localparam int SUM_W = BASE_W + 1;

    logic [MOTOR_W-1:0]     pending_reg;
    logic [COUNT_WIDTH-1:0] compare_reg;
    logic [COUNT_WIDTH-1:0] compare_next;
    logic                   pin_reg;
    logic [TMAX_W-1:0]      clamped;
    logic [SUM_W-1:0]       reload_sum;

    // Clamp the signed pending value to 0..throttle_max
    always_comb begin
        if (pending_reg[MOTOR_W-1]) begin
            clamped = '0;
        end else if (pending_reg > MOTOR_W'(throttle_max)) begin
            clamped = throttle_max;
        end else begin
            clamped = pending_reg[TMAX_W-1:0];
        end
    end

    assign reload_sum   = SUM_W'(pulse_base_ticks) + SUM_W'(clamped);
    assign compare_next = ctrl.reload ? COUNT_WIDTH'(reload_sum) : compare_reg;

    // Pin goes high at a wrap, low when the new count meets the compare
    always_comb begin
        if (ctrl.wrap) begin
            pin_next = 1'b1;
        end else if (ctrl.tick && (compare_reg == count_next)) begin
            pin_next = 1'b0;
        end else begin
            pin_next = pin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            compare_reg <= COUNT_WIDTH'(RST_PULSE_BASE);
            pin_reg     <= 1'b1;
        end else begin
            if (wr_en) begin
                pending_reg <= wr_value;
            end
            compare_reg <= compare_next;
            pin_reg     <= pin_next;
        end
    end

endmodule

>>> sv/oneshot_motor_pwm_with_timebase_unit.sv
// One-shot motor pulse generator with a microsecond timebase. Each input item
// is either a timer tick (s_tuser low) or a write of one channel's pending
// throttle (s_tuser high), and every item yields exactly one result in the
// cycle after it is taken, carrying the pin levels, the time and a period-start
// flag. The block takes one item per clock cycle: all of an item's work is a
// single pass of logic from the counter, accumulator and per-channel compare
// registers into the result register, and s_tready drops only while a result
// waits on m_tready. Configuration writes take effect at the next use;
// compares change only when reloaded at a period wrap with the radio idle.
module oneshot_motor_pwm_with_timebase_unit #(
    parameter int NUM_CHANNELS = ompwm_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_WIDTH  = ompwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config write port
    input  logic                                  cfg_we,
    input  logic [ompwm_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ompwm_pkg::CFG_W-1:0]           cfg_wdata,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // channel[1:0], motor_value[17:2], radio_busy[18], zero [23:19]
    input  logic [ompwm_pkg::S_DATA_W-1:0]        s_tdata,
    // opcode[0]: 0 tick, 1 write pending value
    input  logic                                  s_tuser,
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pwm_levels[NUM_CHANNELS-1:0], time_us above it, zero fill to a byte
    output logic [((NUM_CHANNELS + 32 + 7) / 8) * 8 - 1:0] m_tdata,
    // period_start[0]
    output logic                                  m_tuser
);
    import ompwm_pkg::*;

    localparam int M_DATA_W = ((NUM_CHANNELS + TIME_W + 7) / 8) * 8;

    // Configuration registers
    logic [PERIOD_W-1:0] period_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [TMAX_W-1:0]   tmax_reg;
    logic [SHIFT_W-1:0]  shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= RST_PERIOD_TICKS;
            step_reg   <= RST_TIME_STEP;
            base_reg   <= RST_PULSE_BASE;
            tmax_reg   <= RST_THROTTLE_MAX;
            shift_reg  <= RST_TICK_SHIFT;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PERIOD_TICKS: period_reg <= cfg_wdata[PERIOD_W-1:0];
                REG_TIME_STEP:    step_reg   <= cfg_wdata[STEP_W-1:0];
                REG_PULSE_BASE:   base_reg   <= cfg_wdata[BASE_W-1:0];
                REG_THROTTLE_MAX: tmax_reg   <= cfg_wdata[TMAX_W-1:0];
                REG_TICK_SHIFT:   shift_reg  <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input item decode
    logic                 accept;
    logic                 tick;
    logic                 wr;
    logic [CHAN_W-1:0]    in_channel;
    logic [MOTOR_W-1:0]   in_value;
    logic                 in_busy;

    assign accept     = s_tvalid && s_tready;
    assign tick       = accept && !s_tuser;
    assign wr         = accept && s_tuser;
    assign in_channel = s_tdata[CHAN_W-1:0];
    assign in_value   = s_tdata[CHAN_W +: MOTOR_W];
    assign in_busy    = s_tdata[CHAN_W + MOTOR_W];

    // Shared counter and time accumulator
    ompwm_ctrl_t            ctrl;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [TIME_W-1:0]      time_next;

    ompwm_timebase #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timebase (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .radio_busy   (in_busy),
        .period_ticks (period_reg),
        .time_step_us (step_reg),
        .tick_shift   (shift_reg),
        .ctrl         (ctrl),
        .count_next   (count_next),
        .time_next    (time_next)
    );

    // One pulse channel per motor
    logic [NUM_CHANNELS-1:0] levels_next;

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
        logic wr_en;
        assign wr_en = wr && (32'(in_channel) == i);

        ompwm_channel #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_channel (
            .aclk             (aclk),
            .aresetn          (aresetn),
            .ctrl             (ctrl),
            .count_next       (count_next),
            .wr_en            (wr_en),
            .wr_value         (in_value),
            .pulse_base_ticks (base_reg),
            .throttle_max     (tmax_reg),
            .pin_next         (levels_next[i])
        );
    end

    // Result register; a new item is taken whenever the slot frees this cycle
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [NUM_CHANNELS-1:0] m_levels_reg;
    logic [TIME_W-1:0]       m_time_reg;
    logic                    m_start_reg;

    assign s_tready     = !m_valid_reg || m_tready;
    assign m_valid_next = accept || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_levels_reg <= levels_next;
            m_time_reg   <= time_next;
            m_start_reg  <= ctrl.wrap;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_time_reg, m_levels_reg});
    assign m_tuser  = m_start_reg;

endmodule

>>> sv/ompwm_checker.sv
`include "oneshot_motor_pwm_with_timebase_unit_macros.svh"

module ompwm_checker #(
    parameter int NUM_CHANNELS = ompwm_pkg::NUM_CHANNELS_DEF,
    parameter int M_DATA_W     = 40
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);
    import ompwm_pkg::*;

    // A stalled result holds its payload
    `OMPWM_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

    // Input side is ready exactly when the result slot is free or draining
    `OMPWM_ASSERT_IMPL(a_ready, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not follow result slot")

    // Every accepted item gives a result in the next cycle
    `OMPWM_ASSERT(a_result, aclk, aresetn, (s_tvalid && s_tready) |=> m_tvalid, "accepted item gave no result")

    // A period start drives every pin high
    `OMPWM_ASSERT_IMPL(a_start_high, aclk, aresetn, m_tvalid && m_tuser, m_tdata[NUM_CHANNELS-1:0] == {NUM_CHANNELS{1'b1}}, "pins not all high at period start")

endmodule

bind oneshot_motor_pwm_with_timebase_unit ompwm_checker #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .M_DATA_W     (((NUM_CHANNELS + 32 + 7) / 8) * 8)
) u_ompwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb_oneshot_motor_pwm_with_timebase_unit.sv
`timescale 1ns / 1ps

module tb_oneshot_motor_pwm_with_timebase_unit;
    import ompwm_pkg::*;

    localparam int NCH = NUM_CHANNELS_DEF;
    localparam int M_DATA_W = ((NCH + 32 + 7) / 8) * 8;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 50;

    typedef enum bit {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } motor_op_e;

    typedef struct {
        motor_op_e          opcode;
        logic [1:0]         channel;
        logic signed [15:0] motor_value;
        logic               radio_busy;
    } motor_item_t;

    typedef struct {
        logic [NCH-1:0] levels;
        logic [31:0]    time_us;
        logic           period_start;
    } pwm_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tuser;

    oneshot_motor_pwm_with_timebase_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Predictor copy of the registers
    logic [PERIOD_W-1:0] period_ticks = RST_PERIOD_TICKS;
    logic [STEP_W-1:0]   time_step    = RST_TIME_STEP;
    logic [BASE_W-1:0]   pulse_base   = RST_PULSE_BASE;
    logic [TMAX_W-1:0]   throttle_max = RST_THROTTLE_MAX;
    logic [SHIFT_W-1:0]  tick_shift   = RST_TICK_SHIFT;

    // Predictor copy of the timebase and channel state
    logic [11:0]        period_count = '0;
    logic [31:0]        time_accum = '0;
    logic signed [15:0] pending_throttle [NCH] = '{default: '0};
    logic [11:0]        active_compare [NCH] = '{default: 12'd1000};
    logic [NCH-1:0]     pin_levels = '1;

    motor_item_t pending_items [$];
    pwm_result_t expected_results [$];
    motor_item_t cur_item;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int clamp_throttle(logic signed [15:0] raw);
        if (raw < 0)
            return 0;
        if (int'(raw) > int'(throttle_max))
            return int'(throttle_max);
        return int'(raw);
    endfunction

    // Advance the predicted state by one item and return its result
    function automatic pwm_result_t pwm_model_step(motor_item_t it);
        pwm_result_t r;
        int next_count;
        logic wrapped;
        wrapped = 1'b0;
        if (it.opcode == OP_WRITE) begin
            pending_throttle[it.channel] = it.motor_value;
        end else begin
            next_count = int'(period_count) + 1;
            if (next_count >= int'(period_ticks)) begin
                period_count = '0;
                wrapped = 1'b1;
                time_accum = time_accum + 32'(time_step);
                pin_levels = '1;
                if (!it.radio_busy) begin
                    for (int ch = 0; ch < NCH; ch++)
                        active_compare[ch] =
                            12'(int'(pulse_base) + clamp_throttle(pending_throttle[ch]));
                end
            end else begin
                period_count = 12'(next_count);
                for (int ch = 0; ch < NCH; ch++)
                    if (active_compare[ch] == period_count)
                        pin_levels[ch] = 1'b0;
            end
        end
        r.levels = pin_levels;
        r.time_us = time_accum + (32'(period_count) >> tick_shift);
        r.period_start = wrapped;
        return r;
    endfunction

    function automatic motor_item_t make_item(motor_op_e op, int ch, int val, bit busy);
        motor_item_t it;
        it.opcode = op;
        it.channel = 2'(ch);
        it.motor_value = 16'(val);
        it.radio_busy = busy;
        return it;
    endfunction

    // Mostly ticks, writes split between in-range, negative and raw values
    function automatic motor_item_t random_item();
        motor_item_t it;
        it.opcode = ($urandom_range(99) < 70) ? OP_TICK : OP_WRITE;
        it.channel = 2'($urandom_range(3));
        it.radio_busy = ($urandom_range(99) < 30);
        case ($urandom_range(2))
            0: it.motor_value = 16'($urandom);
            1: it.motor_value = 16'($urandom_range(0, 40));
            default: it.motor_value = 16'(-int'($urandom_range(1, 40)));
        endcase
        return it;
    endfunction

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(pwm_model_step(cur_item));
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, cur_item.radio_busy, cur_item.motor_value,
                                cur_item.channel};
                    s_tuser <= cur_item.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        pwm_result_t exp_r;
        logic [NCH-1:0] got_levels;
        logic [31:0] got_time;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_levels = m_tdata[NCH-1:0];
                got_time = m_tdata[NCH +: 32];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result levels=%h time=%0d start=%b",
                                 $realtime, got_levels, got_time, m_tuser);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_levels !== exp_r.levels || got_time !== exp_r.time_us ||
                        m_tuser !== exp_r.period_start) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "%0t: mismatch exp/act levels %h/%h time %0d/%0d start %b/%b",
                                $realtime, exp_r.levels, got_levels, exp_r.time_us,
                                got_time, exp_r.period_start, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Register write, mirrored into the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_W'(val);
        case (idx)
            REG_PERIOD_TICKS: period_ticks = PERIOD_W'(val);
            REG_TIME_STEP:    time_step = STEP_W'(val);
            REG_PULSE_BASE:   pulse_base = BASE_W'(val);
            REG_THROTTLE_MAX: throttle_max = TMAX_W'(val);
            REG_TICK_SHIFT:   tick_shift = SHIFT_W'(val);
            default: ;
        endcase
    endtask

    task automatic load_config(int period, int step, int base, int tmax, int shift);
        write_reg(REG_PERIOD_TICKS, period);
        write_reg(REG_TIME_STEP, step);
        write_reg(REG_PULSE_BASE, base);
        write_reg(REG_THROTTLE_MAX, tmax);
        write_reg(REG_TICK_SHIFT, shift);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every item is taken and answered, then let the pipe empty
    task automatic drain();
        wait (pending_items.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int period;
        int step;
        int base;
        int tmax;
        int shift;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extreme throttle writes and ignored fields, reset settings
        pending_items.push_back(make_item(OP_WRITE, 0, 32767, 1'b1));
        pending_items.push_back(make_item(OP_WRITE, 1, -32768, 1'b0));
        pending_items.push_back(make_item(OP_WRITE, 2, 0, 1'b1));
        pending_items.push_back(make_item(OP_WRITE, 3, -1, 1'b0));
        pending_items.push_back(make_item(OP_TICK, 3, -1, 1'b1));
        pending_items.push_back(make_item(OP_TICK, 0, 0, 1'b0));
        drain();

        // Directed: short period, busy radio at a wrap, clamping, zero compare
        load_config(4, 4095, 0, 2047, 0);
        @(negedge aclk);
        pending_items.push_back(make_item(OP_WRITE, 2, 2, 1'b0));
        pending_items.push_back(make_item(OP_WRITE, 3, 5000, 1'b0));
        pending_items.push_back(make_item(OP_TICK, 0, 0, 1'b1));
        pending_items.push_back(make_item(OP_TICK, 0, 0, 1'b1));
        for (int i = 0; i < 3; i++)
            pending_items.push_back(make_item(OP_TICK, 2, 7, 1'b0));
        pending_items.push_back(make_item(OP_TICK, 0, 0, 1'b0));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(OP_TICK, 1, -5, 1'b1));
        pending_items.push_back(make_item(OP_WRITE, 1, 1, 1'b1));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(OP_TICK, 3, 0, 1'b0));
        drain();

        // Random phases, each with its own settings and idle pattern
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                1: period = 4095;
                3: period = 0;
                5: period = 1;
                default: period = $urandom_range(2, 40);
            endcase
            if (p == 1)
                step = 0;
            else if (p % 2 == 0)
                step = $urandom_range(0, 4095);
            else
                step = 4095;
            base = (p == 2) ? 2047 : (p == 4) ? 0 : $urandom_range(0, 12);
            tmax = (p == 2) ? 2047 : (p == 6) ? 0 : $urandom_range(0, 30);
            shift = (p == 0) ? 0 : (p == 7) ? 7 : $urandom_range(0, 7);
            load_config(period, step, base, tmax, shift);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            @(negedge aclk);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                pending_items.push_back(random_item());
            drain();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS oneshot_motor_pwm_with_timebase_unit");
        end else begin
            $display("FAIL oneshot_motor_pwm_with_timebase_unit");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAIL oneshot_motor_pwm_with_timebase_unit");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ompwm_pkg.sv
sv/ompwm_timebase.sv
sv/ompwm_channel.sv
sv/oneshot_motor_pwm_with_timebase_unit.sv
sv/ompwm_checker.sv
dv/tb_oneshot_motor_pwm_with_timebase_unit.sv
